// ----- sv/vertex_normal_accumulator_macros.svh -----
// Assertion macros shared by the vertex normal accumulator modules.
// Needs clk and arst_n in the scope of each use.
`ifndef VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH
`define VERTEX_NORMAL_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define VNA_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vertex_normal_accumulator: check failed");

// next-cycle implication
`define VNA_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vertex_normal_accumulator: check failed");

`endif

// ----- sv/vna_pkg.sv -----
// Types and constants of the vertex normal accumulator.
// No dependencies.
package vna_pkg;

	localparam int IDX_W  = 10;
	localparam int POS_W  = 24;
	localparam int CNT_W  = 11;
	localparam int NORM_W = 16;
	localparam int MAG_W  = 52;
	localparam int SQ_W   = 62;
	localparam int ROOT_W = 31;
	localparam int QUO_W  = 15;
	localparam int ONE_Q14 = 16384;

	typedef enum logic [1:0] {
		OPC_WRITE = 2'd0,
		OPC_TRI   = 2'd1,
		OPC_READ  = 2'd2,
		OPC_CLEAR = 2'd3
	} opcode_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ZERO  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [2:0] SEL_A = 3'd0;
	localparam logic [2:0] SEL_B = 3'd1;
	localparam logic [2:0] SEL_C = 3'd2;
	localparam logic [2:0] SEL_V = 3'd3;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLR_INIT,
		DP_CLR,
		DP_POS_RD,
		DP_CROSS,
		DP_SHIFT,
		DP_SQ,
		DP_SQRT,
		DP_DIV_LOAD,
		DP_DIV,
		DP_SUM_RD,
		DP_SUM_LOAD,
		DP_SUM_ACC,
		DP_ZERO_N
	} dp_op_t;

	typedef struct packed {
		logic       accept;
		dp_op_t     op;
		logic [2:0] sel;
	} dp_cmd_t;

	typedef struct packed {
		logic zero;
		logic big;
		logic clr_last;
		logic rng_tri;
		logic rng_v;
	} dp_stat_t;

endpackage

// ----- sv/vna_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vna_ram #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 1024
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- sv/vna_ctrl.sv -----
// Sequencer of the vertex normal accumulator: issues datapath commands.
// Depends on vna_pkg and the assertion macros header.
`include "vertex_normal_accumulator_macros.svh"
module vna_ctrl
	import vna_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] opcode,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd,
	output logic       busy,
	output logic       done,
	output logic [1:0] status
);

	typedef enum logic [4:0] {
		S_IDLE, S_CLR_INIT, S_CLR, S_TRI_CHK, S_RD_CHK, S_SUM_RD, S_SUM_LOAD,
		S_POS_RD, S_POS_WAIT, S_CROSS, S_ZCHK, S_SHIFT, S_SQ, S_SQRT, S_DIV,
		S_ACC_RD, S_ACC_WR, S_OUT, S_OUT_ZERO, S_OUT_ERR
	} state_t;

	state_t     state_q;
	logic [4:0] cnt_q;
	logic [1:0] comp_q;
	logic       is_read_q;
	logic       done_q;
	logic [1:0] status_q;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;

	always_comb begin
		cmd.accept = start && (state_q == S_IDLE);
		cmd.op     = DP_NOP;
		cmd.sel    = 3'(comp_q);
		unique case (state_q)
			S_CLR_INIT: cmd.op = DP_CLR_INIT;
			S_CLR:      cmd.op = DP_CLR;
			S_POS_RD: begin
				cmd.op  = DP_POS_RD;
				cmd.sel = cnt_q[2:0];
			end
			S_CROSS: begin
				cmd.op  = DP_CROSS;
				cmd.sel = cnt_q[2:0];
			end
			S_SHIFT:    cmd.op = stat.big ? DP_SHIFT : DP_NOP;
			S_SQ: begin
				cmd.op  = DP_SQ;
				cmd.sel = cnt_q[2:0];
			end
			S_SQRT:     cmd.op = DP_SQRT;
			S_DIV:      cmd.op = (cnt_q == 5'd0) ? DP_DIV_LOAD : DP_DIV;
			S_SUM_RD: begin
				cmd.op  = DP_SUM_RD;
				cmd.sel = SEL_V;
			end
			S_SUM_LOAD: cmd.op = DP_SUM_LOAD;
			S_ACC_RD:   cmd.op = DP_SUM_RD;
			S_ACC_WR:   cmd.op = DP_SUM_ACC;
			S_OUT_ZERO, S_OUT_ERR: cmd.op = DP_ZERO_N;
			default:    cmd.op = DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR_INIT;
			cnt_q     <= '0;
			comp_q    <= '0;
			is_read_q <= 1'b0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					cnt_q  <= '0;
					comp_q <= '0;
					if (start) begin
						is_read_q <= (opcode == OPC_READ);
						unique case (opcode)
							OPC_TRI:   state_q <= S_TRI_CHK;
							OPC_READ:  state_q <= S_RD_CHK;
							OPC_CLEAR: state_q <= S_CLR_INIT;
							default:   state_q <= S_IDLE;
						endcase
					end
				end
				S_CLR_INIT: state_q <= S_CLR;
				S_CLR: begin
					if (stat.clr_last) begin
						state_q <= S_IDLE;
					end
				end
				S_TRI_CHK:  state_q <= stat.rng_tri ? S_POS_RD : S_IDLE;
				S_RD_CHK:   state_q <= stat.rng_v ? S_SUM_RD : S_OUT_ERR;
				S_SUM_RD:   state_q <= S_SUM_LOAD;
				S_SUM_LOAD: state_q <= S_ZCHK;
				S_POS_RD: begin
					if (cnt_q == 5'd2) begin
						cnt_q   <= '0;
						state_q <= S_POS_WAIT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_POS_WAIT: state_q <= S_CROSS;
				S_CROSS: begin
					if (cnt_q == 5'd6) begin
						cnt_q   <= '0;
						state_q <= S_ZCHK;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_ZCHK: begin
					if (stat.zero) begin
						state_q <= is_read_q ? S_OUT_ZERO : S_IDLE;
					end else begin
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (!stat.big) begin
						state_q <= S_SQ;
					end
				end
				S_SQ: begin
					if (cnt_q == 5'd3) begin
						cnt_q   <= '0;
						state_q <= S_SQRT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_SQRT: begin
					if (cnt_q == 5'(ROOT_W - 1)) begin
						cnt_q   <= '0;
						comp_q  <= '0;
						state_q <= S_DIV;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_DIV: begin
					if (cnt_q == 5'(QUO_W)) begin
						cnt_q <= '0;
						if (comp_q == 2'd2) begin
							comp_q  <= '0;
							state_q <= is_read_q ? S_OUT : S_ACC_RD;
						end else begin
							comp_q <= comp_q + 2'd1;
						end
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_ACC_RD: state_q <= S_ACC_WR;
				S_ACC_WR: begin
					if (comp_q == 2'd2) begin
						state_q <= S_IDLE;
					end else begin
						comp_q  <= comp_q + 2'd1;
						state_q <= S_ACC_RD;
					end
				end
				S_OUT: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					state_q  <= S_IDLE;
				end
				S_OUT_ZERO: begin
					done_q   <= 1'b1;
					status_q <= ST_ZERO;
					state_q  <= S_IDLE;
				end
				S_OUT_ERR: begin
					done_q   <= 1'b1;
					status_q <= ST_RANGE;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`VNA_ASSERT_IMPL(a_done_idle, done_q, state_q == S_IDLE)
	`VNA_ASSERT_NEXT(a_done_single, done_q, !done_q)
	`VNA_ASSERT_IMPL(a_status_code, done_q, (status_q == ST_OK) || (status_q == ST_ZERO) || (status_q == ST_RANGE))

endmodule

// ----- sv/vna_dp.sv -----
// Datapath of the vertex normal accumulator: stores, shared multiplier,
// square root and divider. Depends on vna_pkg, vna_ram and the macros header.
`include "vertex_normal_accumulator_macros.svh"
module vna_dp
	import vna_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int SUM_WIDTH    = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  dp_cmd_t                  cmd,
	output dp_stat_t                 stat,
	input  logic [CNT_W-1:0]         vertex_count,
	input  logic [1:0]               opcode,
	input  logic [IDX_W-1:0]         vertex_index,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	input  logic [IDX_W-1:0]         corner_a,
	input  logic [IDX_W-1:0]         corner_b,
	input  logic [IDX_W-1:0]         corner_c,
	output logic [IDX_W-1:0]         read_index,
	output logic signed [NORM_W-1:0] normal_x,
	output logic signed [NORM_W-1:0] normal_y,
	output logic signed [NORM_W-1:0] normal_z
);

	localparam int AW = $clog2(MAX_VERTICES);
	localparam int SW = SUM_WIDTH;

	logic [IDX_W-1:0]         vi_q, ca_q, cb_q, cc_q;
	logic signed [POS_W-1:0]  pa_q [3];
	logic signed [POS_W:0]    e1_q [3];
	logic signed [POS_W:0]    e2_q [3];
	logic [MAG_W-1:0]         m_q [3];
	logic [2:0]               neg_q;
	logic signed [NORM_W-1:0] n_q [3];
	logic signed [63:0]       prod_q, hold_q;
	logic [SQ_W-1:0]          sq_q;
	logic [ROOT_W-1:0]        rt_q;
	logic [ROOT_W+1:0]        rm_q;
	logic [31:0]              dr_q;
	logic [QUO_W-1:0]         dn_q, q_q;
	logic                     pos_vld_s1;
	logic [1:0]               pos_sel_s1;
	logic [AW-1:0]            clr_q;

	logic [IDX_W-1:0]         sel_idx;
	logic [MAG_W-1:0]         m_sel;
	logic                     neg_sel;
	logic signed [31:0]       mul_a, mul_b;
	logic signed [63:0]       prod;
	logic [3*POS_W-1:0]       pos_rdata;
	logic [3*SW-1:0]          sum_rdata, acc_wdata;
	logic                     pos_we, sum_we;
	logic [AW-1:0]            sum_waddr;

	function automatic logic in_rng(logic [IDX_W-1:0] idx, logic [CNT_W-1:0] cnt);
		in_rng = (32'(idx) < 32'(cnt)) && (32'(idx) < 32'(MAX_VERTICES));
	endfunction

	function automatic logic [SW-1:0] sat_add(logic signed [SW-1:0] a,
			logic signed [NORM_W-1:0] b);
		logic signed [SW:0] s;
		s = $signed({a[SW-1], a}) + (SW+1)'(b);
		if (s[SW] != s[SW-1]) begin
			sat_add = s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
		end else begin
			sat_add = s[SW-1:0];
		end
	endfunction

	always_comb begin
		case (cmd.sel)
			SEL_A:   sel_idx = ca_q;
			SEL_B:   sel_idx = cb_q;
			SEL_C:   sel_idx = cc_q;
			default: sel_idx = vi_q;
		endcase
		case (cmd.sel)
			3'd0: begin
				m_sel   = m_q[0];
				neg_sel = neg_q[0];
			end
			3'd1: begin
				m_sel   = m_q[1];
				neg_sel = neg_q[1];
			end
			3'd2: begin
				m_sel   = m_q[2];
				neg_sel = neg_q[2];
			end
			default: begin
				m_sel   = '0;
				neg_sel = 1'b0;
			end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.op == DP_CROSS) begin
			case (cmd.sel)
				3'd0: begin
					mul_a = 32'(e1_q[1]);
					mul_b = 32'(e2_q[2]);
				end
				3'd1: begin
					mul_a = 32'(e1_q[2]);
					mul_b = 32'(e2_q[1]);
				end
				3'd2: begin
					mul_a = 32'(e1_q[2]);
					mul_b = 32'(e2_q[0]);
				end
				3'd3: begin
					mul_a = 32'(e1_q[0]);
					mul_b = 32'(e2_q[2]);
				end
				3'd4: begin
					mul_a = 32'(e1_q[0]);
					mul_b = 32'(e2_q[1]);
				end
				3'd5: begin
					mul_a = 32'(e1_q[1]);
					mul_b = 32'(e2_q[0]);
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end else if (cmd.op == DP_SQ) begin
			mul_a = $signed({2'b00, m_sel[29:0]});
			mul_b = $signed({2'b00, m_sel[29:0]});
		end
	end

	assign prod = mul_a * mul_b;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_wdata[i*SW +: SW] = sat_add($signed(sum_rdata[i*SW +: SW]), n_q[i]);
		end
	end

	assign pos_we    = cmd.accept && (opcode == OPC_WRITE)
		&& (32'(vertex_index) < 32'(MAX_VERTICES));
	assign sum_we    = (cmd.op == DP_CLR) || (cmd.op == DP_SUM_ACC);
	assign sum_waddr = (cmd.op == DP_CLR) ? clr_q : AW'(sel_idx);

	vna_ram #(.WIDTH(3*POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
		.clk   (clk),
		.we    (pos_we),
		.waddr (AW'(vertex_index)),
		.wdata ({pos_z, pos_y, pos_x}),
		.raddr (AW'(sel_idx)),
		.rdata (pos_rdata)
	);

	vna_ram #(.WIDTH(3*SW), .DEPTH(MAX_VERTICES)) u_sum_ram (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_waddr),
		.wdata ((cmd.op == DP_CLR) ? '0 : acc_wdata),
		.raddr (AW'(sel_idx)),
		.rdata (sum_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_vld_s1 <= 1'b0;
			pos_sel_s1 <= '0;
			clr_q      <= '0;
		end else begin
			pos_vld_s1 <= (cmd.op == DP_POS_RD);
			pos_sel_s1 <= cmd.sel[1:0];
			if (cmd.op == DP_CLR_INIT) begin
				clr_q <= '0;
			end else if (cmd.op == DP_CLR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		logic signed [63:0]    diff;
		logic [63:0]           dmag;
		logic [2:0]            jj;
		logic [44:0]           num;
		logic [ROOT_W+3:0]     rmx, rtt;
		logic [32:0]           rx;
		logic                  qb;
		logic [QUO_W-1:0]      qn;
		logic signed [MAG_W-1:0] sv;
		if (cmd.accept) begin
			vi_q <= vertex_index;
			ca_q <= corner_a;
			cb_q <= corner_b;
			cc_q <= corner_c;
		end
		if (pos_vld_s1) begin
			for (int i = 0; i < 3; i++) begin
				if (pos_sel_s1 == SEL_A[1:0]) begin
					pa_q[i] <= $signed(pos_rdata[i*POS_W +: POS_W]);
				end else if (pos_sel_s1 == SEL_B[1:0]) begin
					e1_q[i] <= $signed((POS_W+1)'($signed(pos_rdata[i*POS_W +: POS_W])))
						- $signed((POS_W+1)'(pa_q[i]));
				end else begin
					e2_q[i] <= $signed((POS_W+1)'($signed(pos_rdata[i*POS_W +: POS_W])))
						- $signed((POS_W+1)'(pa_q[i]));
				end
			end
		end
		case (cmd.op)
			DP_CROSS: begin
				prod_q <= prod;
				if (cmd.sel != 3'd0) begin
					jj = cmd.sel - 3'd1;
					if (!jj[0]) begin
						hold_q <= prod_q;
					end else begin
						diff = hold_q - prod_q;
						dmag = diff[63] ? 64'(-diff) : 64'(diff);
						m_q[jj[2:1]]   <= dmag[MAG_W-1:0];
						neg_q[jj[2:1]] <= diff[63];
					end
				end
			end
			DP_SHIFT: begin
				for (int i = 0; i < 3; i++) begin
					m_q[i] <= m_q[i] >> 1;
				end
			end
			DP_SQ: begin
				prod_q <= prod;
				if (cmd.sel == 3'd0) begin
					sq_q <= '0;
					rt_q <= '0;
					rm_q <= '0;
				end else begin
					sq_q <= sq_q + prod_q[SQ_W-1:0];
				end
			end
			DP_SQRT: begin
				rmx = {rm_q, sq_q[SQ_W-1:SQ_W-2]};
				rtt = {2'b00, rt_q, 2'b01};
				if (rmx >= rtt) begin
					rm_q <= (ROOT_W+2)'(rmx - rtt);
					rt_q <= {rt_q[ROOT_W-2:0], 1'b1};
				end else begin
					rm_q <= rmx[ROOT_W+1:0];
					rt_q <= {rt_q[ROOT_W-2:0], 1'b0};
				end
				sq_q <= sq_q << 2;
			end
			DP_DIV_LOAD: begin
				num  = {1'b0, m_sel[29:0], 14'b0} + 45'(rt_q[ROOT_W-1:1]);
				dr_q <= 32'(num[44:QUO_W]);
				dn_q <= num[QUO_W-1:0];
				q_q  <= '0;
			end
			DP_DIV: begin
				rx = {dr_q, dn_q[QUO_W-1]};
				qb = (rx >= 33'(rt_q));
				dr_q <= qb ? 32'(rx - 33'(rt_q)) : rx[31:0];
				dn_q <= dn_q << 1;
				qn = {q_q[QUO_W-2:0], qb};
				q_q <= qn;
				n_q[cmd.sel[1:0]] <= neg_sel ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
			end
			DP_SUM_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					sv = MAG_W'($signed(sum_rdata[i*SW +: SW]));
					m_q[i]   <= sv[MAG_W-1] ? MAG_W'(-sv) : MAG_W'(sv);
					neg_q[i] <= sv[MAG_W-1];
				end
			end
			DP_ZERO_N: begin
				for (int i = 0; i < 3; i++) begin
					n_q[i] <= '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		stat.zero     = (m_q[0] == '0) && (m_q[1] == '0) && (m_q[2] == '0);
		stat.big      = (|m_q[0][MAG_W-1:30]) || (|m_q[1][MAG_W-1:30])
			|| (|m_q[2][MAG_W-1:30]);
		stat.clr_last = (clr_q == AW'(MAX_VERTICES - 1));
		stat.rng_tri  = in_rng(ca_q, vertex_count) && in_rng(cb_q, vertex_count)
			&& in_rng(cc_q, vertex_count);
		stat.rng_v    = in_rng(vi_q, vertex_count);
	end

	assign read_index = vi_q;
	assign normal_x   = n_q[0];
	assign normal_y   = n_q[1];
	assign normal_z   = n_q[2];

	`VNA_ASSERT_IMPL(a_sq_narrow, cmd.op == DP_SQ, !stat.big)
	`VNA_ASSERT_IMPL(a_norm_hi, cmd.op == DP_SUM_ACC, n_q[0] <= 16'sd16384 && n_q[1] <= 16'sd16384)
	`VNA_ASSERT_IMPL(a_norm_lo, cmd.op == DP_SUM_ACC, n_q[0] >= -16'sd16384 && n_q[2] >= -16'sd16384)

endmodule

// ----- sv/vertex_normal_accumulator.sv -----
// Vertex normal accumulator top level: APB register, controller, datapath.
// Depends on vna_pkg, vna_ctrl, vna_dp.
//
// Usage: vertex_count is written over APB at byte address 0 while idle.
// Items are taken on start while busy is low; opcode selects one of:
// write position (no busy time), add triangle, read normal, clear sums.
// A read returns one result: read_index, normal_x/y/z and status on the
// result ports for one cycle, marked by done. The receiver cannot stall.
// Triangle: each normalizing shift (up to 19) lengthens the busy time;
// skipped triangles end early. Read: likewise, with no shifts at the
// default sum width, and an early end when out of range. The busy time
// is set by the shared 32x32 multiplier, the bit-serial square root
// (31 result bits) and the restoring divider, one axis after another.
// Clear: one pass over the accumulator memory, one entry a cycle.
// Reset: vertex_count goes to 0 and a clearing pass zeroes the accumulators;
// busy stays high until it ends. Positions are undefined until written.
module vertex_normal_accumulator
	import vna_pkg::*;
#(
	parameter int MAX_VERTICES = 1024,
	parameter int SUM_WIDTH    = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [2:0]               paddr,
	input  logic [31:0]              pwdata,
	output logic [31:0]              prdata,
	output logic                     pready,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               opcode,
	input  logic [IDX_W-1:0]         vertex_index,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	input  logic [IDX_W-1:0]         corner_a,
	input  logic [IDX_W-1:0]         corner_b,
	input  logic [IDX_W-1:0]         corner_c,
	output logic                     done,
	output logic [IDX_W-1:0]         read_index,
	output logic signed [NORM_W-1:0] normal_x,
	output logic signed [NORM_W-1:0] normal_y,
	output logic signed [NORM_W-1:0] normal_z,
	output logic [1:0]               status
);

	localparam logic REG_VERTEX_COUNT = 1'b0;

	logic [CNT_W-1:0] vertex_count_q;
	dp_cmd_t          cmd;
	dp_stat_t         stat;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_VERTEX_COUNT) ? 32'(vertex_count_q) : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == REG_VERTEX_COUNT)) begin
			vertex_count_q <= pwdata[CNT_W-1:0];
		end
	end

	vna_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.status (status)
	);

	vna_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.SUM_WIDTH    (SUM_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.vertex_count (vertex_count_q),
		.opcode       (opcode),
		.vertex_index (vertex_index),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.corner_a     (corner_a),
		.corner_b     (corner_b),
		.corner_c     (corner_c),
		.read_index   (read_index),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z)
	);

endmodule
